// ----- hdl/uvf_pkg.sv -----
// Shared constants and the token type passed along the cell chain.
package uvf_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      found;
      logic                      stored;
      logic [CNT_W-1:0]          count;
   } token_type;

endpackage

// ----- hdl/uvf_if.sv -----
// Valid/ready channel interfaces for the request and response streams.
interface uvf_req_if
   import uvf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last_element;

   modport source (output valid, output value, output last_element, input ready);
   modport sink   (input valid, input value, input last_element, output ready);
endinterface

interface uvf_rsp_if
   import uvf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic                      is_unique;
   logic [COUNT_W-1:0]        unique_count;
   logic                      dropped_full;
   logic                      out_last;

   modport source (output valid, output out_value, output is_unique, output unique_count,
                   output dropped_full, output out_last, input ready);
   modport sink   (input valid, input out_value, input is_unique, input unique_count,
                   input dropped_full, input out_last, output ready);
endinterface

// ----- hdl/uvf_cell.sv -----
// One store cell: holds one value, checks each token, claims it if empty and new.
module uvf_cell
   import uvf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type tok_in,
   output token_type tok_out
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      full_ff, full_in;
   token_type                 pass_ff, pass_in;
   logic                      hit, take;

   always_comb begin
      hit  = tok_in.valid && full_ff && (entry_ff == tok_in.value);
      take = tok_in.valid && !full_ff && !tok_in.found && !tok_in.stored;

      pass_in        = tok_in;
      pass_in.found  = tok_in.found | hit;
      pass_in.stored = tok_in.stored | take;
      pass_in.count  = tok_in.count + CNT_W'(full_ff | take);

      entry_in = entry_ff;
      full_in  = full_ff;
      if (take) begin
         entry_in = tok_in.value;
         full_in  = 1'b1;
      end
      // the end of an array empties each cell as its last token passes
      if (tok_in.valid && tok_in.last) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else if (advance) begin
         full_ff <= full_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign tok_out = pass_ff;

endmodule

// ----- hdl/unique_value_filter.sv -----
// Streaming de-duplication filter built from a chain of store cells.
//
//  channel | dir | payload                                                   | handshake
//  req_ch  | in  | value, last_element                                       | valid/ready
//  rsp_ch  | out | out_value, is_unique, unique_count, dropped_full, out_last | valid/ready
//
// One transaction enters per cycle while the chain is not frozen; each one walks the cell chain,
// one cell each time the chain advances, and its response is registered after the last cell.
// Reset empties every cell and flushes the chain; stored values need no clearing.
// A stalled response register freezes the whole chain and drops req_ch.ready.
module unique_value_filter
   import uvf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   uvf_req_if.sink       req_ch,
   uvf_rsp_if.source     rsp_ch
);

   token_type tok [STORE_DEPTH+1];
   logic      advance;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_unique_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_dropped_ff;
   logic                      rsp_last_ff;
   token_type                 tail;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign tok[0] = '{valid:  req_ch.valid,
                     value:  req_ch.value,
                     last:   req_ch.last_element,
                     found:  1'b0,
                     stored: 1'b0,
                     count:  {CNT_W{1'b0}}};

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      uvf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign tail = tok[STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   // hold the payload while the response stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff   <= tail.value;
         rsp_unique_ff  <= tail.stored;
         rsp_count_ff   <= COUNT_W'(tail.count);
         rsp_dropped_ff <= !tail.found && !tail.stored;
         rsp_last_ff    <= tail.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_value    = rsp_value_ff;
   assign rsp_ch.is_unique    = rsp_unique_ff;
   assign rsp_ch.unique_count = rsp_count_ff;
   assign rsp_ch.dropped_full = rsp_dropped_ff;
   assign rsp_ch.out_last     = rsp_last_ff;

endmodule

// ----- hdl/uvf_checker.sv -----
// Port-level checks on the filter's response stream, bound to the top level.
module uvf_checker
   import uvf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_value,
   input logic               rsp_unique,
   input logic [COUNT_W-1:0] rsp_count,
   input logic               rsp_dropped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response changed while stalled");

   a_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_unique_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unique |-> !rsp_dropped)
      else $error("transaction both stored and dropped");

   a_unique_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unique |-> rsp_count != '0)
      else $error("stored transaction reports an empty store");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_count == COUNT_W'(STORE_DEPTH))
      else $error("drop reported with room left in the store");

endmodule

bind unique_value_filter uvf_checker u_uvf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_value   (rsp_ch.out_value),
   .rsp_unique  (rsp_ch.is_unique),
   .rsp_count   (rsp_ch.unique_count),
   .rsp_dropped (rsp_ch.dropped_full)
);
